// ----- hdl/bgcd_pkg.sv -----
// Shared types and constants for the gradient-corrected Bayer demosaic core.
// No dependencies; imported by every module of the block.
package bgcd_pkg;

  // Config register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CFA_PHASE    = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_e;

  localparam int unsigned DefMaxWidth   = 4096;
  localparam int unsigned DefSampleBits = 16;
  localparam int unsigned MinDim        = 5;
  localparam int unsigned Pad           = 2;
  localparam int unsigned NumLines      = 4;
  localparam logic [12:0] ResetWidth    = 13'd4096;
  localparam logic [15:0] ResetHeight   = 16'd3072;

  // Per-item control that follows the pipeline
  typedef struct packed {
    logic produce;   // pixel is interior, a result is due
    logic rr;        // row parity after phase
    logic cc;        // column parity after phase
    logic fend;      // last interior pixel of the frame
  } pix_meta_t;

endpackage

// ----- hdl/bgcd_line_store.sv -----
// Four line banks of raw samples, one read and one write port each.
// Depends on bgcd_pkg.
module bgcd_line_store
  import bgcd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = DefMaxWidth,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  logic [1:0]                   wbank_i,
  input  logic [SAMPLE_BITS-1:0]       wdata_i,
  output logic [SAMPLE_BITS-1:0]       rdata_o [NumLines]
);

  // Each bank reads the old entry while the same entry is overwritten
  for (genvar b = 0; b < NumLines; b++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q <= mem[addr_i];
        if (wbank_i == 2'(b)) begin
          mem[addr_i] <= wdata_i;
        end
      end
    end

    assign rdata_o[b] = rd_q;
  end

endmodule

// ----- hdl/bgcd_kernel.sv -----
// Gradient-corrected 5x5 kernels and round/clamp for one window position.
// Depends on bgcd_pkg.
module bgcd_kernel
  import bgcd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic [4:0][4:0][SAMPLE_BITS-1:0] win_i,
  input  pix_meta_t                        meta_i,
  output logic [SAMPLE_BITS-1:0]           red_o,
  output logic [SAMPLE_BITS-1:0]           green_o,
  output logic [SAMPLE_BITS-1:0]           blue_o
);

  localparam int unsigned SW = SAMPLE_BITS + 7;
  localparam logic signed [SW-1:0] Top = SW'((1 << SAMPLE_BITS) - 1);

  function automatic logic signed [SW-1:0] px(input logic [SAMPLE_BITS-1:0] v);
    px = signed'(SW'(v));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat_round(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] v;
    t = s + SW'(8);
    v = t >>> 4;
    if (t < 0) sat_round = '0;
    else if (v > Top) sat_round = '1;
    else sat_round = v[SAMPLE_BITS-1:0];
  endfunction

  logic signed [SW-1:0] ctr, cross1, cross2, diag, vert1, horz1, vert2, horz2;
  logic signed [SW-1:0] k_g_rb, k_horiz, k_vert, k_opp;

  // Neighborhood sums around the center win[2][2]
  always_comb begin
    ctr    = px(win_i[2][2]);
    vert1  = px(win_i[1][2]) + px(win_i[3][2]);
    horz1  = px(win_i[2][1]) + px(win_i[2][3]);
    vert2  = px(win_i[0][2]) + px(win_i[4][2]);
    horz2  = px(win_i[2][0]) + px(win_i[2][4]);
    cross1 = vert1 + horz1;
    cross2 = vert2 + horz2;
    diag   = px(win_i[1][1]) + px(win_i[1][3]) + px(win_i[3][1]) + px(win_i[3][3]);

    k_g_rb  = (cross1 <<< 2) + (ctr <<< 3) - (cross2 <<< 1);
    k_horiz = (horz1 <<< 3) + (ctr <<< 3) + (ctr <<< 1) + vert2
              - (diag <<< 1) - (horz2 <<< 1);
    k_vert  = (vert1 <<< 3) + (ctr <<< 3) + (ctr <<< 1) + horz2
              - (diag <<< 1) - (vert2 <<< 1);
    k_opp   = (diag <<< 2) + (ctr <<< 3) + (ctr <<< 2) - (cross2 <<< 1) - cross2;
  end

  // Site type selects the kernel per channel
  always_comb begin
    unique case ({meta_i.rr, meta_i.cc})
      2'b00: begin
        red_o   = win_i[2][2];
        green_o = sat_round(k_g_rb);
        blue_o  = sat_round(k_opp);
      end
      2'b11: begin
        red_o   = sat_round(k_opp);
        green_o = sat_round(k_g_rb);
        blue_o  = win_i[2][2];
      end
      2'b01: begin
        red_o   = sat_round(k_horiz);
        green_o = win_i[2][2];
        blue_o  = sat_round(k_vert);
      end
      default: begin
        red_o   = sat_round(k_vert);
        green_o = win_i[2][2];
        blue_o  = sat_round(k_horiz);
      end
    endcase
  end

endmodule

// ----- hdl/bayer_gradient_corrected_demosaic_core.sv -----
// Top level of the gradient-corrected Bayer demosaic core.
// Depends on bgcd_pkg, bgcd_line_store and bgcd_kernel.
//
// Takes one raw sample per clock in raster order and returns full RGB for each
// interior pixel (two in from every edge); border pixels give no output. A
// sample at line r, column c (r, c >= 4) yields the pixel at (r-2, c-2): the
// line-store read and the input stage load when the sample is accepted, then
// the window shifts and then the kernel sums land in the output register.
// Throughput is one sample per clock whenever the output side is ready.
// Line stores need no clearing after reset. Configure only while idle.
module bayer_gradient_corrected_demosaic_core
  import bgcd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = DefMaxWidth,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // raw sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] raw_sample
  input  logic        s_axis_tuser,   // frame_start
  // RGB stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] red, [31:16] green, [47:32] blue
  output logic        m_axis_tlast    // frame_end
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
  localparam logic [16:0] MinD = 17'(MinDim);

  // Config registers
  logic [12:0] fw_q;
  logic [15:0] fh_q;
  logic [1:0]  phase_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= ResetWidth;
      fh_q    <= ResetHeight;
      phase_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  fw_q    <= cfg_data_i[12:0];
        REG_FRAME_HEIGHT: fh_q    <= cfg_data_i;
        REG_CFA_PHASE:    phase_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless the output is held
  logic out_valid_q, adv, acc;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // Effective frame size
  logic [16:0] w_eff, h_eff;
  always_comb begin
    w_eff = 17'(fw_q);
    if (w_eff < MinD) w_eff = MinD;
    if (w_eff > MaxW) w_eff = MaxW;
    h_eff = 17'(fh_q);
    if (h_eff < MinD) h_eff = MinD;
  end

  // Position of the incoming sample
  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic [16:0]   c_cur, r_cur;
  logic [CW-1:0] c_use;
  logic [15:0]   r_use;
  pix_meta_t     meta_in;

  always_comb begin
    c_cur = 17'(col_q);
    r_cur = 17'(row_q);
    if (s_axis_tuser) begin
      c_cur = '0;
      r_cur = '0;
    end
    if (c_cur >= w_eff) begin
      c_cur = '0;
      r_cur = r_cur + 17'd1;
    end
    if (r_cur >= h_eff) r_cur = '0;
    c_use = c_cur[CW-1:0];
    r_use = r_cur[15:0];

    meta_in.produce = (r_use >= 16'd4) && (c_use >= CW'(4));
    meta_in.rr      = r_use[0] ^ phase_q[1];
    meta_in.cc      = c_use[0] ^ phase_q[0];
    meta_in.fend    = (r_cur == h_eff - 17'd1) && (c_cur == w_eff - 17'd1);

    if (c_cur + 17'd1 >= w_eff) begin
      col_d = '0;
      row_d = (r_cur + 17'd1 >= h_eff) ? 16'd0 : 16'(r_cur + 17'd1);
    end else begin
      col_d = CW'(c_cur + 17'd1);
      row_d = r_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] ls_rd [NumLines];
  assign sample = s_axis_tdata[SAMPLE_BITS-1:0];

  bgcd_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lines (
    .clk_i  (clk_i),
    .en_i   (acc),
    .addr_i (c_use),
    .wbank_i(r_use[1:0]),
    .wdata_i(sample),
    .rdata_o(ls_rd)
  );

  // Stage 1: read data returns
  logic                   s1_valid_q;
  pix_meta_t              s1_meta_q;
  logic [1:0]             s1_bank_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_meta_q   <= meta_in;
      s1_bank_q   <= r_use[1:0];
      s1_sample_q <= sample;
    end
  end

  // Stage 2: 5x5 window shift
  logic [4:0][4:0][SAMPLE_BITS-1:0] win_q;
  logic                             s2_valid_q;
  pix_meta_t                        s2_meta_q;

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      for (int y = 0; y < 5; y++) begin
        for (int x = 0; x < 4; x++) begin
          win_q[y][x] <= win_q[y][x+1];
        end
      end
      for (int y = 0; y < 4; y++) begin
        win_q[y][4] <= ls_rd[2'(s1_bank_q + 2'(y))];
      end
      win_q[4][4] <= s1_sample_q;
      s2_meta_q   <= s1_meta_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 3: kernels into the output register
  logic [SAMPLE_BITS-1:0] red, green, blue;
  logic [SAMPLE_BITS-1:0] red_q, green_q, blue_q;
  logic                   fend_q;

  bgcd_kernel #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_kernel (
    .win_i  (win_q),
    .meta_i (s2_meta_q),
    .red_o  (red),
    .green_o(green),
    .blue_o (blue)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q && s2_meta_q.produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      fend_q  <= s2_meta_q.fend;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = fend_q;
  assign m_axis_tdata  = {16'(blue_q), 16'(green_q), 16'(red_q)};

`ifndef SYNTH
  // A held result is never dropped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q)
    else $error("result dropped while stalled");

  // A result only follows a valid window stage
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q))
    else $error("result without window stage");

  // Stalled stage 1 keeps its item
  a_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_meta_q))
    else $error("stage 1 item lost in stall");
`endif

endmodule
